>>> hw/rtl/vbcr_pkg.sv
// shared constants and types for the legacy virtio block register file
package vbcr_pkg;

    localparam int CapWidth   = 54;
    localparam int DataWidth  = 32;
    localparam int DepthWidth = 16;
    localparam int CfgIdxWidth = 2;

    typedef logic [1:0] t_req_type;
    typedef logic [7:0] t_offset;
    typedef logic [2:0] t_size;

    localparam t_req_type REQ_READ  = 2'd0;
    localparam t_req_type REQ_WRITE = 2'd1;
    localparam t_req_type REQ_DONE  = 2'd2;
    localparam t_req_type REQ_FAULT = 2'd3;

    localparam t_offset OFF_DEV_FEAT   = 8'd0;
    localparam t_offset OFF_GUEST_FEAT = 8'd4;
    localparam t_offset OFF_QPFN       = 8'd8;
    localparam t_offset OFF_QSIZE      = 8'd12;
    localparam t_offset OFF_QSEL       = 8'd14;
    localparam t_offset OFF_QNOTIFY    = 8'd16;
    localparam t_offset OFF_STATUS     = 8'd18;
    localparam t_offset OFF_ISR        = 8'd19;
    localparam t_offset OFF_CAP        = 8'd20;
    localparam t_offset OFF_CAP_LAST   = 8'd27;
    localparam t_offset OFF_SEGMAX     = 8'd32;
    localparam t_offset OFF_SEGMAX_LAST = 8'd35;

    localparam logic [CfgIdxWidth-1:0] CFG_CAPACITY = 2'd0;
    localparam logic [CfgIdxWidth-1:0] CFG_SEGMAX   = 2'd1;
    localparam logic [CfgIdxWidth-1:0] CFG_FEATURES = 2'd2;
    localparam logic [CfgIdxWidth-1:0] CFG_QDEPTH   = 2'd3;

    localparam logic [DepthWidth-1:0] QDEPTH_RESET = 16'd128;

    localparam int STATUS_NEEDS_RESET_BIT = 6;
    localparam int ISR_QUEUE_BIT  = 0;
    localparam int ISR_CONFIG_BIT = 1;

    localparam logic [DataWidth-1:0] ALL_ONES   = 32'hFFFF_FFFF;
    localparam logic [DataWidth-1:0] KEEP_HIGH2 = 32'hFFFF_0000;
    localparam logic [DataWidth-1:0] KEEP_HIGH3 = 32'hFFFF_FF00;

    localparam t_size SIZE_1 = 3'd1;
    localparam t_size SIZE_2 = 3'd2;
    localparam t_size SIZE_4 = 3'd4;

endpackage

>>> hw/rtl/vbcr_cfg_read.sv
// device config space read: byte lane select and merge into prior bus data
module vbcr_cfg_read (
    input  logic [vbcr_pkg::CapWidth-1:0]  i_capacity,
    input  logic [vbcr_pkg::DataWidth-1:0] i_segment_max,
    input  vbcr_pkg::t_offset              i_offset,
    input  vbcr_pkg::t_size                i_size,
    input  logic [vbcr_pkg::DataWidth-1:0] i_prior,
    output logic                           o_hit,
    output logic [vbcr_pkg::DataWidth-1:0] o_data
);
    import vbcr_pkg::*;

    logic        in_cap;
    logic        in_seg;
    logic [2:0]  lane;
    logic [63:0] src;
    logic [63:0] shifted;
    t_offset     rel;

    always_comb begin
        in_cap  = (i_offset inside {[OFF_CAP:OFF_CAP_LAST]});
        in_seg  = (i_offset inside {[OFF_SEGMAX:OFF_SEGMAX_LAST]});
        o_hit   = in_cap || in_seg;
        rel     = in_cap ? (i_offset - OFF_CAP) : (i_offset - OFF_SEGMAX);
        lane    = rel[2:0];
        src     = in_cap ? {{(64-CapWidth){1'b0}}, i_capacity}
                         : {{(64-DataWidth){1'b0}}, i_segment_max};
        shifted = src >> {lane, 3'b000};
        if (i_size == SIZE_4 && lane[1:0] == 2'b00) begin
            o_data = shifted[31:0];
        end else if (i_size == SIZE_2 && lane[0] == 1'b0) begin
            o_data = (i_prior & KEEP_HIGH2) | {16'h0000, shifted[15:0]};
        end else if (i_size == SIZE_1) begin
            o_data = (i_prior & KEEP_HIGH3) | {24'h000000, shifted[7:0]};
        end else begin
            o_data = i_prior;
        end
    end

endmodule

>>> hw/rtl/virtio_block_config_registers_unit.sv
// legacy virtio block register file: decode, state update and result register
//
// channel | direction | handshake               | word
// --------+-----------+-------------------------+----------------------------------------
// in      | input     | i_in_valid / o_in_ready | req_type, reg_offset, access_size, data
// out     | output    | o_out_valid / i_out_ready | read_data, irq flags, queue_kick
// cfg     | input     | i_cfg_we                | index, data (no read-back)
//
// state updates at the accepting edge, result is registered
// a new word is taken every cycle while the result register is empty or draining
// synchronous active-low reset clears register state and out valid, not the result word; queue_depth resets to 128
// a stalled result holds the input side off only while it is not being taken
module virtio_block_config_registers_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [vbcr_pkg::CfgIdxWidth-1:0]  i_cfg_idx,
    input  logic [vbcr_pkg::CapWidth-1:0]     i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  vbcr_pkg::t_req_type               i_req_type,
    input  vbcr_pkg::t_offset                 i_reg_offset,
    input  vbcr_pkg::t_size                   i_access_size,
    input  logic [vbcr_pkg::DataWidth-1:0]    i_bus_data,
    input  logic                              i_bus_data_valid,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [vbcr_pkg::DataWidth-1:0]    o_read_data,
    output logic                              o_irq_assert,
    output logic                              o_irq_deassert,
    output logic                              o_queue_kick
);
    import vbcr_pkg::*;

    logic [CapWidth-1:0]   r_capacity;
    logic [DataWidth-1:0]  r_segmax;
    logic [DataWidth-1:0]  r_dev_feat;
    logic [DepthWidth-1:0] r_qdepth;

    logic [DataWidth-1:0]  r_guest_feat, n_guest_feat;
    logic [DataWidth-1:0]  r_qpfn_view,  n_qpfn_view;
    logic [DataWidth-1:0]  r_q0_page,    n_q0_page;
    logic [15:0]           r_qsize_view, n_qsize_view;
    logic [15:0]           r_qsel,       n_qsel;
    logic [15:0]           r_qnotify,    n_qnotify;
    logic [7:0]            r_status,     n_status;
    logic [7:0]            r_isr,        n_isr;

    logic                  r_out_valid;
    logic [DataWidth-1:0]  r_read_data,  n_read_data;
    logic                  r_irq_assert, n_irq_assert;
    logic                  r_irq_deassert, n_irq_deassert;
    logic                  r_kick,       n_kick;

    logic                  accept;
    logic                  cfg_hit;
    logic [DataWidth-1:0]  cfg_data;
    logic [DataWidth-1:0]  prior;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign prior      = i_bus_data_valid ? i_bus_data : '0;

    vbcr_cfg_read u_cfg_read (
        .i_capacity    (r_capacity),
        .i_segment_max (r_segmax),
        .i_offset      (i_reg_offset),
        .i_size        (i_access_size),
        .i_prior       (prior),
        .o_hit         (cfg_hit),
        .o_data        (cfg_data)
    );

    always_comb begin
        n_guest_feat   = r_guest_feat;
        n_qpfn_view    = r_qpfn_view;
        n_q0_page      = r_q0_page;
        n_qsize_view   = r_qsize_view;
        n_qsel         = r_qsel;
        n_qnotify      = r_qnotify;
        n_status       = r_status;
        n_isr          = r_isr;
        n_read_data    = '0;
        n_irq_assert   = 1'b0;
        n_irq_deassert = 1'b0;
        n_kick         = 1'b0;
        case (i_req_type)
            REQ_READ: begin
                if (cfg_hit) begin
                    n_read_data = cfg_data;
                end else begin
                    case (i_reg_offset)
                        OFF_DEV_FEAT:   n_read_data = r_dev_feat;
                        OFF_GUEST_FEAT: n_read_data = r_guest_feat;
                        OFF_QPFN:       n_read_data = r_qpfn_view;
                        OFF_QSIZE:      n_read_data = {16'h0000, r_qsize_view};
                        OFF_QSEL:       n_read_data = {16'h0000, r_qsel};
                        OFF_QNOTIFY:    n_read_data = {16'h0000, r_qnotify};
                        OFF_STATUS:     n_read_data = {24'h000000, r_status};
                        OFF_ISR: begin
                            n_read_data    = {24'h000000, r_isr};
                            n_isr          = '0;
                            n_irq_deassert = 1'b1;
                        end
                        default:        n_read_data = ALL_ONES;
                    endcase
                end
            end
            REQ_WRITE: begin
                case (i_reg_offset)
                    OFF_GUEST_FEAT: n_guest_feat = i_bus_data;
                    OFF_QPFN: begin
                        n_qpfn_view = i_bus_data;
                        if (r_qsel == 16'h0000) begin
                            n_q0_page = i_bus_data;
                        end
                    end
                    OFF_QSEL: begin
                        n_qsel = i_bus_data[15:0];
                        if (i_bus_data[15:0] != 16'h0000) begin
                            n_qsize_view = '0;
                        end else begin
                            n_qpfn_view  = r_q0_page;
                            n_qsize_view = r_qdepth;
                        end
                    end
                    OFF_QNOTIFY: begin
                        if (!r_status[STATUS_NEEDS_RESET_BIT]) begin
                            n_qnotify = i_bus_data[15:0];
                            n_kick    = (i_bus_data[15:0] == 16'h0000);
                        end
                    end
                    OFF_STATUS: begin
                        n_status = i_bus_data[7:0];
                        if (i_bus_data[7:0] == 8'h00) begin
                            n_guest_feat   = '0;
                            n_q0_page      = '0;
                            n_qsel         = '0;
                            n_qnotify      = '0;
                            n_isr          = '0;
                            n_qpfn_view    = '0;
                            n_qsize_view   = r_qdepth;
                            n_irq_deassert = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            REQ_DONE: begin
                n_isr[ISR_QUEUE_BIT] = 1'b1;
                n_irq_assert         = 1'b1;
            end
            REQ_FAULT: begin
                n_status[STATUS_NEEDS_RESET_BIT] = 1'b1;
                n_isr[ISR_CONFIG_BIT]            = 1'b1;
                n_irq_assert                     = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= '0;
            r_segmax   <= '0;
            r_dev_feat <= '0;
            r_qdepth   <= QDEPTH_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CAPACITY: r_capacity <= i_cfg_data;
                CFG_SEGMAX:   r_segmax   <= i_cfg_data[DataWidth-1:0];
                CFG_FEATURES: r_dev_feat <= i_cfg_data[DataWidth-1:0];
                CFG_QDEPTH:   r_qdepth   <= i_cfg_data[DepthWidth-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_guest_feat <= '0;
            r_qpfn_view  <= '0;
            r_q0_page    <= '0;
            r_qsize_view <= '0;
            r_qsel       <= '0;
            r_qnotify    <= '0;
            r_status     <= '0;
            r_isr        <= '0;
        end else if (accept) begin
            r_guest_feat <= n_guest_feat;
            r_qpfn_view  <= n_qpfn_view;
            r_q0_page    <= n_q0_page;
            r_qsize_view <= n_qsize_view;
            r_qsel       <= n_qsel;
            r_qnotify    <= n_qnotify;
            r_status     <= n_status;
            r_isr        <= n_isr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_out_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_read_data    <= n_read_data;
            r_irq_assert   <= n_irq_assert;
            r_irq_deassert <= n_irq_deassert;
            r_kick         <= n_kick;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_read_data    = r_read_data;
    assign o_irq_assert   = r_irq_assert;
    assign o_irq_deassert = r_irq_deassert;
    assign o_queue_kick   = r_kick;

    a_irq_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_irq_assert && r_irq_deassert))
        else $error("irq assert and deassert in one word");

    a_kick_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_kick) |-> (r_read_data == '0 && !r_irq_assert))
        else $error("kick with read data or irq");

    a_fault_sets_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_req_type == REQ_FAULT) |=> r_status[STATUS_NEEDS_RESET_BIT])
        else $error("fault did not set needs-reset");

    a_size_view_other_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_qsel != 16'h0000) |-> (r_qsize_view == 16'h0000))
        else $error("size view nonzero for other queue");

    a_pfn_view_queue0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_qsel == 16'h0000) |-> (r_qpfn_view == r_q0_page))
        else $error("pfn view out of step with queue zero page");

endmodule

>>> bench/virtio_block_config_registers_unit_tb.sv
// testbench for the legacy virtio block register file: directed and random bus words against a predictor
module virtio_block_config_registers_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import vbcr_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 90;
    localparam int PHASE_WORDS    = 265;
    localparam logic [CapWidth-1:0] CFG_ALL_ONES = {CapWidth{1'b1}};

    typedef struct packed {
        logic [DataWidth-1:0] read_data;
        logic                 irq_assert;
        logic                 irq_deassert;
        logic                 queue_kick;
    } t_response;

    class reg_file_scoreboard;
        logic [CapWidth-1:0]   capacity;
        logic [DataWidth-1:0]  seg_max;
        logic [DataWidth-1:0]  dev_features;
        logic [DepthWidth-1:0] q_depth;
        logic [31:0]           guest_features;
        logic [31:0]           pfn_view;
        logic [31:0]           q0_page;
        logic [15:0]           size_view;
        logic [15:0]           q_select;
        logic [15:0]           q_notify;
        logic [7:0]            dev_status;
        logic [7:0]            isr;
        t_response             pending_responses[$];
        int                    errors;

        function void reset_state();
            capacity       = '0;
            seg_max        = '0;
            dev_features   = '0;
            q_depth        = QDEPTH_RESET;
            guest_features = '0;
            pfn_view       = '0;
            q0_page        = '0;
            size_view      = '0;
            q_select       = '0;
            q_notify       = '0;
            dev_status     = '0;
            isr            = '0;
            errors         = 0;
        endfunction

        function void write_config(logic [CfgIdxWidth-1:0] idx, logic [CapWidth-1:0] value);
            case (idx)
                CFG_CAPACITY: capacity     = value;
                CFG_SEGMAX:   seg_max      = value[DataWidth-1:0];
                CFG_FEATURES: dev_features = value[DataWidth-1:0];
                CFG_QDEPTH:   q_depth      = value[DepthWidth-1:0];
                default: ;
            endcase
        endfunction

        function logic [31:0] merge_lanes(logic [31:0] prior, logic [63:0] field,
                                          int unsigned lane, t_size sz);
            logic [63:0] shifted;
            shifted = field >> (lane * 8);
            if (sz == SIZE_4 && lane[1:0] == 2'd0)
                return shifted[31:0];
            else if (sz == SIZE_2 && lane[0] == 1'b0)
                return (prior & KEEP_HIGH2) | {16'h0, shifted[15:0]};
            else if (sz == SIZE_1)
                return (prior & KEEP_HIGH3) | {24'h0, shifted[7:0]};
            return prior;
        endfunction

        function void show_selected_queue();
            if (q_select != 16'h0) begin
                size_view = '0;
            end else begin
                pfn_view  = q0_page;
                size_view = q_depth;
            end
        endfunction

        function void note_access(t_req_type kind, t_offset off, t_size sz,
                                  logic [31:0] data, logic data_ok);
            t_response   r;
            logic [31:0] prior;
            r     = '0;
            prior = data_ok ? data : 32'h0;
            case (kind)
                REQ_READ: begin
                    if (off >= OFF_CAP && off <= OFF_CAP_LAST) begin
                        r.read_data = merge_lanes(prior, 64'(capacity), 32'(off - OFF_CAP), sz);
                    end else if (off >= OFF_SEGMAX && off <= OFF_SEGMAX_LAST) begin
                        r.read_data = merge_lanes(prior, 64'(seg_max), 32'(off - OFF_SEGMAX),
                                                  sz);
                    end else begin
                        case (off)
                            OFF_DEV_FEAT:   r.read_data = dev_features;
                            OFF_GUEST_FEAT: r.read_data = guest_features;
                            OFF_QPFN:       r.read_data = pfn_view;
                            OFF_QSIZE:      r.read_data = 32'(size_view);
                            OFF_QSEL:       r.read_data = 32'(q_select);
                            OFF_QNOTIFY:    r.read_data = 32'(q_notify);
                            OFF_STATUS:     r.read_data = 32'(dev_status);
                            OFF_ISR: begin
                                r.read_data    = 32'(isr);
                                isr            = '0;
                                r.irq_deassert = 1'b1;
                            end
                            default:        r.read_data = ALL_ONES;
                        endcase
                    end
                end
                REQ_WRITE: begin
                    case (off)
                        OFF_GUEST_FEAT: guest_features = data;
                        OFF_QPFN: begin
                            pfn_view = data;
                            if (q_select == 16'h0)
                                q0_page = data;
                        end
                        OFF_QSEL: begin
                            q_select = data[15:0];
                            show_selected_queue();
                        end
                        OFF_QNOTIFY: begin
                            if (!dev_status[STATUS_NEEDS_RESET_BIT]) begin
                                q_notify = data[15:0];
                                if (q_notify == 16'h0)
                                    r.queue_kick = 1'b1;
                            end
                        end
                        OFF_STATUS: begin
                            dev_status = data[7:0];
                            if (dev_status == 8'h0) begin
                                guest_features = '0;
                                q0_page        = '0;
                                q_select       = '0;
                                q_notify       = '0;
                                isr            = '0;
                                show_selected_queue();
                                r.irq_deassert = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
                REQ_DONE: begin
                    isr[ISR_QUEUE_BIT] = 1'b1;
                    r.irq_assert       = 1'b1;
                end
                default: begin
                    dev_status[STATUS_NEEDS_RESET_BIT] = 1'b1;
                    isr[ISR_CONFIG_BIT]                = 1'b1;
                    r.irq_assert                       = 1'b1;
                end
            endcase
            pending_responses.push_back(r);
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            if (errors < 50)
                $display("mismatch %s: got %h, expected %h", what, got, want);
            errors++;
        endtask

        task check_response(t_response got);
            t_response want;
            if (pending_responses.size() == 0) begin
                report("word with none pending", got.read_data, 32'h0);
            end else begin
                want = pending_responses.pop_front();
                if (got.read_data !== want.read_data)
                    report("read_data", got.read_data, want.read_data);
                if (got.irq_assert !== want.irq_assert)
                    report("irq_assert", 32'(got.irq_assert), 32'(want.irq_assert));
                if (got.irq_deassert !== want.irq_deassert)
                    report("irq_deassert", 32'(got.irq_deassert), 32'(want.irq_deassert));
                if (got.queue_kick !== want.queue_kick)
                    report("queue_kick", 32'(got.queue_kick), 32'(want.queue_kick));
            end
        endtask
    endclass

    logic                   i_clk            = 1'b0;
    logic                   i_rst_n          = 1'b0;
    logic                   i_cfg_we         = 1'b0;
    logic [CfgIdxWidth-1:0] i_cfg_idx        = CFG_CAPACITY;
    logic [CapWidth-1:0]    i_cfg_data       = '0;
    logic                   i_in_valid       = 1'b0;
    t_req_type              i_req_type       = REQ_READ;
    t_offset                i_reg_offset     = OFF_DEV_FEAT;
    t_size                  i_access_size    = SIZE_4;
    logic [DataWidth-1:0]   i_bus_data       = '0;
    logic                   i_bus_data_valid = 1'b0;
    logic                   i_out_ready      = 1'b0;
    logic                   o_in_ready;
    logic                   o_out_valid;
    logic [DataWidth-1:0]   o_read_data;
    logic                   o_irq_assert;
    logic                   o_irq_deassert;
    logic                   o_queue_kick;

    reg_file_scoreboard sb;
    bit  idle_on      = 1'b1;
    bit  hold_request = 1'b0;
    int  quiet_cycles = 0;
    int  words_sent   = 0;

    t_offset reg_offsets[8] = '{OFF_DEV_FEAT, OFF_GUEST_FEAT, OFF_QPFN, OFF_QSIZE,
                                OFF_QSEL, OFF_QNOTIFY, OFF_STATUS, OFF_ISR};
    t_size   common_sizes[3] = '{SIZE_1, SIZE_2, SIZE_4};

    virtio_block_config_registers_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_req_type       (i_req_type),
        .i_reg_offset     (i_reg_offset),
        .i_access_size    (i_access_size),
        .i_bus_data       (i_bus_data),
        .i_bus_data_valid (i_bus_data_valid),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_read_data      (o_read_data),
        .o_irq_assert     (o_irq_assert),
        .o_irq_deassert   (o_irq_deassert),
        .o_queue_kick     (o_queue_kick)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready)
                sb.check_response({o_read_data, o_irq_assert, o_irq_deassert, o_queue_kick});
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_we)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT)
            @(posedge i_clk);
        $display("** virtio_block_config_registers_unit: FAILED **");
        $finish;
    end

    // result side: random stalls plus one long hold on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (idle_on && $urandom_range(0, 9) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    task automatic send_word(t_req_type kind, t_offset off, t_size sz,
                             logic [31:0] data, logic data_ok);
        int gap;
        gap = (idle_on && $urandom_range(0, 7) == 0) ? int'($urandom_range(1, 17)) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_req_type       <= kind;
        i_reg_offset     <= off;
        i_access_size    <= sz;
        i_bus_data       <= data;
        i_bus_data_valid <= data_ok;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_access(kind, off, sz, data, data_ok);
        words_sent++;
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (sb.pending_responses.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic configure(logic [CapWidth-1:0] cap, logic [CapWidth-1:0] seg,
                             logic [CapWidth-1:0] feat, logic [CapWidth-1:0] depth);
        logic [CfgIdxWidth-1:0] idx_list[4];
        logic [CapWidth-1:0]    vals[4];
        idx_list = '{CFG_CAPACITY, CFG_SEGMAX, CFG_FEATURES, CFG_QDEPTH};
        vals     = '{cap, seg, feat, depth};
        for (int i = 0; i < 4; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idx_list[i];
            i_cfg_data <= vals[i];
            @(posedge i_clk);
            sb.write_config(idx_list[i], vals[i]);
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_random_word();
        t_req_type   kind;
        t_offset     off;
        t_size       sz;
        logic [31:0] data;
        int          r;
        r    = $urandom_range(0, 99);
        kind = r < 45 ? REQ_READ : r < 85 ? REQ_WRITE : r < 96 ? REQ_DONE : REQ_FAULT;
        r    = $urandom_range(0, 99);
        if (r < 40)
            off = reg_offsets[$urandom_range(0, 7)];
        else if (r < 60)
            off = OFF_CAP + t_offset'($urandom_range(0, 7));
        else if (r < 72)
            off = OFF_SEGMAX + t_offset'($urandom_range(0, 3));
        else if (r < 85)
            off = t_offset'($urandom_range(28, 39));
        else
            off = t_offset'($urandom_range(0, 255));
        sz   = ($urandom_range(0, 6) != 0) ? common_sizes[$urandom_range(0, 2)]
                                           : t_size'($urandom_range(0, 7));
        data = $urandom;
        if (kind == REQ_WRITE) begin
            case (off)
                OFF_QSEL, OFF_QNOTIFY: begin
                    if ($urandom_range(0, 2) != 0)
                        data[15:0] = 16'($urandom_range(0, 2));
                end
                OFF_STATUS: begin
                    if ($urandom_range(0, 3) == 0)
                        data[7:0] = 8'h0;
                    else if ($urandom_range(0, 1) == 1)
                        data[STATUS_NEEDS_RESET_BIT] = 1'b0;
                end
                default: ;
            endcase
        end
        send_word(kind, off, sz, data, 1'($urandom_range(0, 1)));
    endtask

    // driver bring-up: reset, status, features, queue zero setup, random words, notify and interrupt
    task automatic send_bringup();
        logic [31:0] status_val;
        status_val = $urandom;
        status_val[STATUS_NEEDS_RESET_BIT] = 1'b0;
        status_val[0] = 1'b1;
        send_word(REQ_WRITE, OFF_STATUS, SIZE_1, {24'($urandom), 8'h00}, 1'b0);
        send_word(REQ_WRITE, OFF_STATUS, SIZE_1, status_val, 1'b0);
        send_word(REQ_READ, OFF_DEV_FEAT, SIZE_4, $urandom, 1'($urandom_range(0, 1)));
        send_word(REQ_WRITE, OFF_GUEST_FEAT, SIZE_4, $urandom, 1'b1);
        send_word(REQ_WRITE, OFF_QSEL, SIZE_2, {16'($urandom), 16'h0}, 1'b1);
        send_word(REQ_READ, OFF_QSIZE, SIZE_2, $urandom, 1'($urandom_range(0, 1)));
        send_word(REQ_WRITE, OFF_QPFN, SIZE_4, $urandom, 1'b1);
        repeat ($urandom_range(0, 6)) send_random_word();
        send_word(REQ_WRITE, OFF_QNOTIFY, SIZE_2, {16'($urandom), 16'h0}, 1'b1);
        send_word(REQ_DONE, OFF_DEV_FEAT, SIZE_4, $urandom, 1'b0);
        send_word(REQ_READ, OFF_ISR, SIZE_1, $urandom, 1'($urandom_range(0, 1)));
    endtask

    task automatic run_phase(logic [CapWidth-1:0] cap, logic [CapWidth-1:0] seg,
                             logic [CapWidth-1:0] feat, logic [CapWidth-1:0] depth,
                             bit with_hold);
        int start;
        bit held;
        wait_drained();
        configure(cap, seg, feat, depth);
        start = words_sent;
        held  = 1'b0;
        while (words_sent - start < PHASE_WORDS) begin
            if (with_hold && !held && words_sent - start >= PHASE_WORDS / 2) begin
                hold_request = 1'b1;
                held = 1'b1;
            end
            if ($urandom_range(0, 9) < 3)
                send_bringup();
            else
                send_random_word();
        end
    endtask

    initial begin
        sb = new;
        sb.reset_state();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset values before any register write
        send_word(REQ_READ, OFF_QSIZE, SIZE_2, 32'hFFFF_FFFF, 1'b1);
        send_word(REQ_READ, OFF_CAP, SIZE_4, 32'hFFFF_FFFF, 1'b1);
        send_word(REQ_READ, OFF_STATUS, SIZE_1, 32'h0, 1'b0);

        wait_drained();
        configure(54'h3A_B1C2_D3E4_F506, 54'h8765_4321, 54'hA5A5_5A5A, 54'hFFFF);
        send_word(REQ_WRITE, OFF_STATUS, SIZE_1, 32'hFFFF_FF00, 1'b1);
        send_word(REQ_READ, OFF_QSIZE, SIZE_2, 32'h0, 1'b0);
        send_word(REQ_READ, OFF_CAP, SIZE_4, 32'hFFFF_FFFF, 1'b1);
        send_word(REQ_READ, OFF_CAP + 8'd4, SIZE_4, 32'hFFFF_FFFF, 1'b0);
        send_word(REQ_READ, OFF_CAP + 8'd2, SIZE_2, 32'hFFFF_FFFF, 1'b1);
        send_word(REQ_READ, OFF_CAP_LAST, SIZE_1, 32'h1234_5678, 1'b1);
        send_word(REQ_READ, OFF_CAP + 8'd1, SIZE_2, 32'hDEAD_BEEF, 1'b1);
        send_word(REQ_READ, OFF_CAP, 3'd3, 32'h0BAD_CAFE, 1'b1);
        send_word(REQ_READ, OFF_SEGMAX + 8'd1, SIZE_4, 32'hCAFE_F00D, 1'b1);
        send_word(REQ_READ, OFF_SEGMAX_LAST, SIZE_1, 32'hFFFF_FFFF, 1'b0);
        send_word(REQ_READ, OFF_SEGMAX, 3'd0, 32'h5555_AAAA, 1'b1);
        send_word(REQ_READ, 8'hFF, SIZE_4, 32'h0, 1'b1);
        send_word(REQ_WRITE, OFF_DEV_FEAT, SIZE_4, 32'hFFFF_FFFF, 1'b1);
        send_word(REQ_READ, OFF_DEV_FEAT, SIZE_4, 32'h0, 1'b1);
        send_word(REQ_WRITE, OFF_GUEST_FEAT, SIZE_4, 32'hFFFF_FFFF, 1'b1);
        send_word(REQ_WRITE, OFF_QPFN, SIZE_4, 32'h0001_2345, 1'b1);
        send_word(REQ_WRITE, OFF_QSEL, SIZE_2, 32'hFFFF_0001, 1'b1);
        send_word(REQ_WRITE, OFF_QPFN, SIZE_4, 32'h0000_BEEF, 1'b1);
        send_word(REQ_READ, OFF_QSIZE, SIZE_2, 32'h0, 1'b1);
        send_word(REQ_WRITE, OFF_QSEL, SIZE_2, 32'h0, 1'b1);
        send_word(REQ_READ, OFF_QPFN, SIZE_4, 32'h0, 1'b1);
        send_word(REQ_WRITE, OFF_QNOTIFY, SIZE_2, 32'h0, 1'b1);
        send_word(REQ_WRITE, OFF_QNOTIFY, SIZE_2, 32'hFFFF_0005, 1'b1);
        send_word(REQ_DONE, OFF_DEV_FEAT, SIZE_4, 32'h0, 1'b0);
        send_word(REQ_FAULT, OFF_DEV_FEAT, SIZE_4, 32'h0, 1'b0);
        send_word(REQ_WRITE, OFF_QNOTIFY, SIZE_2, 32'h0, 1'b1);
        send_word(REQ_READ, OFF_ISR, SIZE_1, 32'h0, 1'b1);
        send_word(REQ_WRITE, OFF_STATUS, SIZE_1, 32'h0, 1'b1);

        run_phase('0, '0, '0, '0, 1'b0);
        run_phase(CFG_ALL_ONES, CFG_ALL_ONES, CFG_ALL_ONES, CFG_ALL_ONES, 1'b1);
        run_phase(CapWidth'({$urandom, $urandom}), CapWidth'({$urandom, $urandom}),
                  CapWidth'({$urandom, $urandom}), CapWidth'({$urandom, $urandom}), 1'b0);
        run_phase(CapWidth'({$urandom, $urandom}), CapWidth'({$urandom, $urandom}),
                  CapWidth'({$urandom, $urandom}), 54'($urandom_range(0, 3)), 1'b0);
        idle_on = 1'b0;
        run_phase(CapWidth'({$urandom, $urandom}), CapWidth'({$urandom, $urandom}),
                  CapWidth'({$urandom, $urandom}), CapWidth'({$urandom, $urandom}), 1'b0);

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_responses.size() == 0)
            $display("** virtio_block_config_registers_unit: PASSED **");
        else
            $display("** virtio_block_config_registers_unit: FAILED **");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/vbcr_pkg.sv
hw/rtl/vbcr_cfg_read.sv
hw/rtl/virtio_block_config_registers_unit.sv
bench/virtio_block_config_registers_unit_tb.sv
